>>> sv/svf_pkg.sv
// svf_pkg: shared types, constants and the tanh table generator for the
// multimode state-variable filter; no dependencies
package svf_pkg;

	// sample, coefficient and state formats
	localparam int SAMPLE_BITS     = 24;
	localparam int SFRAC           = SAMPLE_BITS - 1;
	localparam int COEFF_FRAC_BITS = 20;
	localparam int STATE_BITS      = 32;
	localparam int DRIVE_FRAC      = 12;

	// configuration register widths
	localparam int MODE_W  = 3;
	localparam int FREQ_W  = 24;
	localparam int DAMP_W  = 22;
	localparam int GAIN_W  = 21;
	localparam int NOTCH_W = 22;
	localparam int DRIVE_W = 16;

	// configuration register reset values
	localparam logic [MODE_W-1:0]  FILTER_MODE_RST   = 3'd0;
	localparam logic [FREQ_W-1:0]  FREQ_COEFF_RST    = 24'd68700;
	localparam logic [DAMP_W-1:0]  STAGE_DAMPING_RST = 22'd1482910;
	localparam logic [GAIN_W-1:0]  STAGE_GAIN_RST    = 21'd955960;
	localparam logic [NOTCH_W-1:0] NOTCH_DAMPING_RST = 22'd1482910;
	localparam logic [DRIVE_W-1:0] DRIVE_GAIN_RST    = 16'd4096;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// tanh table geometry: entries cover arguments 0 to 8
	localparam int TAB_ENTRIES = 256;
	localparam int TAB_BITS    = $clog2(TAB_ENTRIES);
	localparam int TANH_SHIFT  = SFRAC + 3;
	localparam int IDX_SHIFT   = TANH_SHIFT - TAB_BITS;
	localparam int DRV_W       = SAMPLE_BITS + DRIVE_W - DRIVE_FRAC;
	localparam int IDX_W       = DRV_W - IDX_SHIFT;

	// shared multiplier and accumulation widths
	localparam int B_W    = TANH_SHIFT + 1;
	localparam int MUL_W  = STATE_BITS + B_W;
	localparam int RND_W  = MUL_W - DRIVE_FRAC;
	localparam int WIDE_W = RND_W + 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_LP12  = 3'd0,
		MODE_LP24  = 3'd1,
		MODE_HP    = 3'd2,
		MODE_BP    = 3'd3,
		MODE_NOTCH = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_FREQ     = 3'd1,
		REG_DAMP     = 3'd2,
		REG_GAIN     = 3'd3,
		REG_NOTCH    = 3'd4,
		REG_DRIVE    = 3'd5,
		REG_DRIVE_EN = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [MODE_W-1:0]  filter_mode;
		logic [FREQ_W-1:0]  freq_coeff;
		logic [DAMP_W-1:0]  stage_damping;
		logic [GAIN_W-1:0]  stage_gain;
		logic [NOTCH_W-1:0] notch_damping;
		logic [DRIVE_W-1:0] drive_gain;
		logic               drive_enable;
	} cfg_t;

	// multiplier operand selects
	typedef enum logic [2:0] {
		A_X, A_DIFF, A_S1, A_T, A_HP, A_BP
	} a_sel_t;

	typedef enum logic [2:0] {
		B_DRIVE, B_FRAC, B_GR, B_H, B_G, B_NOTCH
	} b_sel_t;

	// rounding shift applied to the registered product
	typedef enum logic [1:0] {
		RND_COEF, RND_DRIVE, RND_TANH
	} rnd_sel_t;

	// datapath register update operations
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DRIVE, OP_TAB, OP_TANH, OP_T, OP_HP,
		OP_BP, OP_S1, OP_LP, OP_S2, OP_NOTCH, OP_OUT
	} op_t;

	typedef struct packed {
		op_t      op;
		logic     mul_en;
		a_sel_t   mul_a;
		b_sel_t   mul_b;
		rnd_sel_t rnd;
		logic     stage;
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DRV_MUL, S_DRV_RND, S_TAB_RD, S_TAB_MUL, S_TAB_RND,
		S_M1, S_T, S_M2, S_HP, S_M3, S_BP, S_S1, S_M4, S_LP, S_S2,
		S_N_MUL, S_N_SUB, S_OUT
	} state_t;

	// unsigned quotient by shift, compare and subtract, used only at elaboration
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem, quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// one point of the tanh table, evaluated at elaboration
	// e = r^k in Q30 with r = exp(-16/N) from a truncated taylor series
	function automatic logic [SAMPLE_BITS-1:0] tanh_point(input int k);
		logic [63:0] one, d, term, r, e, num, den, q;
		one  = 64'd1 << 30;
		d    = (one * 64'd16) >> TAB_BITS;
		term = one;
		r    = one;
		e    = one;
		for (int n = 1; n <= 24; n++) begin
			term = udiv64((term * d) >> 30, 64'(n));
			if (n[0]) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		for (int j = 0; j < k; j++) begin
			e = (e * r + (one >> 1)) >> 30;
		end
		num = (one - e) << SFRAC;
		den = one + e;
		q   = udiv64(num + (den >> 1), den);
		return q[SAMPLE_BITS-1:0];
	endfunction

endpackage

>>> sv/svf_multimode_filter.sv
// svf_multimode_filter: one item is in flight at a time; a new input is accepted
// only after the last has entered the output register. The sequence on the
// single shared multiplier has 10 steps per filter stage (two stages in lowpass24),
// 5 for the soft-clip drive, 2 for the notch subtraction, plus accept and output.
// An async active-low reset restores the register defaults and zeroes all
// integrators; a finished result waits in the output register while the next loads.
module svf_multimode_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [svf_pkg::PADDR_W-1:0]          paddr,
	input  logic [svf_pkg::PDATA_W-1:0]          pwdata,
	output logic [svf_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                 clear_state,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                 clipped
);
	import svf_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	// configuration registers
	svf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	svf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath
	svf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sample_in   (sample_in),
		.clear_state (clear_state),
		.sample_out  (sample_out),
		.clipped     (clipped)
	);

endmodule

>>> sv/svf_cfg.sv
// svf_cfg: configuration register file behind the apb-style port
// depends on svf_pkg
module svf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [svf_pkg::PADDR_W-1:0] paddr,
	input  logic [svf_pkg::PDATA_W-1:0] pwdata,
	output logic [svf_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output svf_pkg::cfg_t               cfg
);
	import svf_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes, each keeps only its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode   <= FILTER_MODE_RST;
			cfg_q.freq_coeff    <= FREQ_COEFF_RST;
			cfg_q.stage_damping <= STAGE_DAMPING_RST;
			cfg_q.stage_gain    <= STAGE_GAIN_RST;
			cfg_q.notch_damping <= NOTCH_DAMPING_RST;
			cfg_q.drive_gain    <= DRIVE_GAIN_RST;
			cfg_q.drive_enable  <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:     cfg_q.filter_mode   <= pwdata[MODE_W-1:0];
				REG_FREQ:     cfg_q.freq_coeff    <= pwdata[FREQ_W-1:0];
				REG_DAMP:     cfg_q.stage_damping <= pwdata[DAMP_W-1:0];
				REG_GAIN:     cfg_q.stage_gain    <= pwdata[GAIN_W-1:0];
				REG_NOTCH:    cfg_q.notch_damping <= pwdata[NOTCH_W-1:0];
				REG_DRIVE:    cfg_q.drive_gain    <= pwdata[DRIVE_W-1:0];
				REG_DRIVE_EN: cfg_q.drive_enable  <= pwdata[0];
				default:      ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_MODE:     prdata = PDATA_W'(cfg_q.filter_mode);
			REG_FREQ:     prdata = PDATA_W'(cfg_q.freq_coeff);
			REG_DAMP:     prdata = PDATA_W'(cfg_q.stage_damping);
			REG_GAIN:     prdata = PDATA_W'(cfg_q.stage_gain);
			REG_NOTCH:    prdata = PDATA_W'(cfg_q.notch_damping);
			REG_DRIVE:    prdata = PDATA_W'(cfg_q.drive_gain);
			REG_DRIVE_EN: prdata = PDATA_W'(cfg_q.drive_enable);
			default:      prdata = '0;
		endcase
	end

endmodule

>>> sv/svf_ctrl.sv
// svf_ctrl: sequencer that steps the shared multiplier through drive,
// filter stages and output; depends on svf_pkg
module svf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  svf_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output svf_pkg::cmd_t cmd
);
	import svf_pkg::*;

	state_t state_q, state_d;
	logic   stage_q;
	logic   out_valid_q;
	logic   out_free;
	logic   is_lp24;
	logic   is_notch;

	assign out_free  = !out_valid_q || out_ready;
	assign is_lp24   = (cfg.filter_mode == MODE_LP24);
	assign is_notch  = (cfg.filter_mode == MODE_NOTCH);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// state, stage index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stage_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				stage_q <= 1'b0;
			end else if (state_q == S_S2 && is_lp24 && !stage_q) begin
				stage_q <= 1'b1;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = cfg.drive_enable ? S_DRV_MUL : S_M1;
				end
			end
			S_DRV_MUL: state_d = S_DRV_RND;
			S_DRV_RND: state_d = S_TAB_RD;
			S_TAB_RD:  state_d = S_TAB_MUL;
			S_TAB_MUL: state_d = S_TAB_RND;
			S_TAB_RND: state_d = S_M1;
			S_M1:      state_d = S_T;
			S_T:       state_d = S_M2;
			S_M2:      state_d = S_HP;
			S_HP:      state_d = S_M3;
			S_M3:      state_d = S_BP;
			S_BP:      state_d = S_S1;
			S_S1:      state_d = S_M4;
			S_M4:      state_d = S_LP;
			S_LP:      state_d = S_S2;
			S_S2: begin
				if (is_lp24 && !stage_q) begin
					state_d = S_M1;
				end else if (is_notch) begin
					state_d = S_N_MUL;
				end else begin
					state_d = S_OUT;
				end
			end
			S_N_MUL:   state_d = S_N_SUB;
			S_N_SUB:   state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op     = OP_NONE;
		cmd.mul_en = 1'b0;
		cmd.mul_a  = A_X;
		cmd.mul_b  = B_G;
		cmd.rnd    = RND_COEF;
		cmd.stage  = stage_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			S_DRV_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = A_X;
				cmd.mul_b  = B_DRIVE;
			end
			S_DRV_RND: begin
				cmd.op  = OP_DRIVE;
				cmd.rnd = RND_DRIVE;
			end
			S_TAB_RD:  cmd.op = OP_TAB;
			S_TAB_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = A_DIFF;
				cmd.mul_b  = B_FRAC;
			end
			S_TAB_RND: begin
				cmd.op  = OP_TANH;
				cmd.rnd = RND_TANH;
			end
			S_M1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = A_S1;
				cmd.mul_b  = B_GR;
			end
			S_T:  cmd.op = OP_T;
			S_M2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = A_T;
				cmd.mul_b  = B_H;
			end
			S_HP: cmd.op = OP_HP;
			S_M3: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = A_HP;
				cmd.mul_b  = B_G;
			end
			S_BP: cmd.op = OP_BP;
			S_S1: cmd.op = OP_S1;
			S_M4: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = A_BP;
				cmd.mul_b  = B_G;
			end
			S_LP: cmd.op = OP_LP;
			S_S2: cmd.op = OP_S2;
			S_N_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = A_BP;
				cmd.mul_b  = B_NOTCH;
			end
			S_N_SUB: cmd.op = OP_NOTCH;
			S_OUT: begin
				if (out_free) begin
					cmd.op = OP_OUT;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> sv/svf_dp.sv
// svf_dp: filter datapath with one shared multiplier, integrator state,
// tanh table and output register; depends on svf_pkg
module svf_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svf_pkg::cfg_t                        cfg,
	input  svf_pkg::cmd_t                        cmd,
	input  logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                 clear_state,
	output logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                 clipped
);
	import svf_pkg::*;

	localparam logic signed [MUL_W-1:0] HALF_COEF = MUL_W'(1) <<< (COEFF_FRAC_BITS - 1);
	localparam logic signed [MUL_W-1:0] HALF_DRV  = MUL_W'(1) <<< (DRIVE_FRAC - 1);
	localparam logic signed [MUL_W-1:0] HALF_TANH = MUL_W'(1) <<< (TANH_SHIFT - 1);

	// saturate a wide value to the state width
	function automatic logic signed [STATE_BITS-1:0] sat_st(
		input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-STATE_BITS:0] top;
		top = v[WIDE_W-1:STATE_BITS-1];
		if (&top || ~|top) begin
			return v[STATE_BITS-1:0];
		end
		return v[WIDE_W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
		                   : {1'b0, {(STATE_BITS-1){1'b1}}};
	endfunction

	// tanh table as constant logic
	logic [SAMPLE_BITS-1:0] tab_rom [TAB_ENTRIES+1];
	for (genvar k = 0; k <= TAB_ENTRIES; k++) begin : g_tab
		localparam logic [SAMPLE_BITS-1:0] POINT = tanh_point(k);
		assign tab_rom[k] = POINT;
	end

	// working registers
	logic signed [STATE_BITS-1:0]  x_q, t_q, hp_q, bp_q, lp_q;
	logic signed [STATE_BITS-1:0]  s1_q [2];
	logic signed [STATE_BITS-1:0]  s2_q [2];
	logic signed [RND_W-1:0]       v_q;
	logic signed [WIDE_W-1:0]      y_q;
	logic        [FREQ_W:0]        gr_q;
	logic signed [MUL_W-1:0]       prod_q;
	logic                          neg_q;
	logic        [DRV_W-1:0]       mag_q;
	logic signed [SAMPLE_BITS:0]   t0_q;
	logic signed [SAMPLE_BITS:0]   diff_q;
	logic        [IDX_SHIFT-1:0]   frac_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	logic signed [STATE_BITS-1:0] a_op;
	logic signed [B_W-1:0]        b_op;
	logic signed [MUL_W-1:0]      rsh;
	logic signed [RND_W-1:0]      rnd;
	logic signed [STATE_BITS-1:0] x_src, s1_cur, s2_cur;
	logic signed [DRV_W-1:0]      xd;
	logic        [IDX_W-1:0]      idx;
	logic        [TAB_BITS:0]     idx_lo, idx_hi;
	logic signed [WIDE_W-1:0]     tanh_y;
	logic signed [WIDE_W-1:0]     y_sel;
	logic        [WIDE_W-SAMPLE_BITS:0] y_top;
	logic                         y_fits;

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;
	assign x_src      = cmd.stage ? lp_q : x_q;
	assign s1_cur     = s1_q[cmd.stage];
	assign s2_cur     = s2_q[cmd.stage];

	// multiplier operand selection
	always_comb begin
		case (cmd.mul_a)
			A_X:     a_op = x_q;
			A_DIFF:  a_op = STATE_BITS'(diff_q);
			A_S1:    a_op = s1_cur;
			A_T:     a_op = t_q;
			A_HP:    a_op = hp_q;
			A_BP:    a_op = bp_q;
			default: a_op = x_q;
		endcase
		case (cmd.mul_b)
			B_DRIVE: b_op = B_W'(cfg.drive_gain);
			B_FRAC:  b_op = B_W'({frac_q, {TAB_BITS{1'b0}}});
			B_GR:    b_op = B_W'(gr_q);
			B_H:     b_op = B_W'(cfg.stage_gain);
			B_G:     b_op = B_W'(cfg.freq_coeff);
			B_NOTCH: b_op = B_W'(cfg.notch_damping);
			default: b_op = B_W'(cfg.freq_coeff);
		endcase
	end

	// round half up on the registered product
	always_comb begin
		case (cmd.rnd)
			RND_DRIVE: rsh = (prod_q + HALF_DRV) >>> DRIVE_FRAC;
			RND_TANH:  rsh = (prod_q + HALF_TANH) >>> TANH_SHIFT;
			default:   rsh = (prod_q + HALF_COEF) >>> COEFF_FRAC_BITS;
		endcase
		rnd = rsh[RND_W-1:0];
	end

	// soft clip helpers
	assign xd     = rnd[DRV_W-1:0];
	assign idx    = mag_q[DRV_W-1:IDX_SHIFT];
	assign idx_lo = {1'b0, idx[TAB_BITS-1:0]};
	assign idx_hi = idx_lo + (TAB_BITS+1)'(1);
	assign tanh_y = WIDE_W'(t0_q) + WIDE_W'(rnd);

	// output selection and saturation to sample width
	always_comb begin
		case (cfg.filter_mode)
			MODE_LP12, MODE_LP24: y_sel = WIDE_W'(lp_q);
			MODE_HP:              y_sel = WIDE_W'(hp_q);
			MODE_BP:              y_sel = WIDE_W'(bp_q);
			MODE_NOTCH:           y_sel = y_q;
			default:              y_sel = WIDE_W'(x_q);
		endcase
		y_top  = y_sel[WIDE_W-1:SAMPLE_BITS-1];
		y_fits = &y_top || ~|y_top;
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= a_op * b_op;
		end
	end

	// integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q[0] <= '0;
			s1_q[1] <= '0;
			s2_q[0] <= '0;
			s2_q[1] <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (clear_state) begin
						s1_q[0] <= '0;
						s1_q[1] <= '0;
						s2_q[0] <= '0;
						s2_q[1] <= '0;
					end
				end
				OP_S1:   s1_q[cmd.stage] <= sat_st(WIDE_W'(v_q) + WIDE_W'(bp_q));
				OP_S2:   s2_q[cmd.stage] <= sat_st(WIDE_W'(v_q) + WIDE_W'(lp_q));
				default: ;
			endcase
		end
	end

	// working and output registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q  <= STATE_BITS'(sample_in);
				gr_q <= (FREQ_W+1)'(cfg.freq_coeff) + (FREQ_W+1)'(cfg.stage_damping);
			end
			OP_DRIVE: begin
				neg_q <= xd[DRV_W-1];
				mag_q <= xd[DRV_W-1] ? DRV_W'(-xd) : DRV_W'(xd);
			end
			OP_TAB: begin
				frac_q <= mag_q[IDX_SHIFT-1:0];
				if (idx >= IDX_W'(TAB_ENTRIES)) begin
					t0_q   <= {1'b0, tab_rom[TAB_ENTRIES]};
					diff_q <= '0;
				end else begin
					t0_q   <= {1'b0, tab_rom[idx_lo]};
					diff_q <= $signed({1'b0, tab_rom[idx_hi]}) -
					          $signed({1'b0, tab_rom[idx_lo]});
				end
			end
			OP_TANH:  x_q  <= neg_q ? STATE_BITS'(-tanh_y) : STATE_BITS'(tanh_y);
			OP_T: begin
				t_q <= sat_st(WIDE_W'(x_src) - WIDE_W'(rnd) - WIDE_W'(s2_cur));
			end
			OP_HP:    hp_q <= sat_st(WIDE_W'(rnd));
			OP_BP: begin
				v_q  <= rnd;
				bp_q <= sat_st(WIDE_W'(rnd) + WIDE_W'(s1_cur));
			end
			OP_LP: begin
				v_q  <= rnd;
				lp_q <= sat_st(WIDE_W'(rnd) + WIDE_W'(s2_cur));
			end
			OP_NOTCH: y_q  <= WIDE_W'(x_q) - WIDE_W'(rnd);
			OP_OUT: begin
				clipped_q <= !y_fits;
				if (y_fits) begin
					sample_out_q <= y_sel[SAMPLE_BITS-1:0];
				end else if (y_sel[WIDE_W-1]) begin
					sample_out_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
				end else begin
					sample_out_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
				end
			end
			default: ;
		endcase
	end

endmodule

>>> sv/svf_checker.sv
// svf_checker: port-level assertions for svf_multimode_filter, bound to the top
// depends on svf_pkg and svf_multimode_filter
module svf_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_out,
	input logic                                   clipped
);
	import svf_pkg::*;

	localparam logic [SAMPLE_BITS-1:0] OUT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] OUT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
		else $error("output payload changed while stalled");

	// one item at a time: busy right after an input transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// a clipped result carries a full-scale value
	a_clip_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> sample_out == OUT_HI || sample_out == OUT_LO)
		else $error("clipped flag without a saturated sample");

	// no result appears in the cycle right after an input transaction
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared too early");

endmodule

bind svf_multimode_filter svf_checker u_svf_checker (.*);
